[rtl/voxel_histogram_min_max_defines.svh]
// Assertion macros shared by the histogram checker.
`ifndef VOXEL_HISTOGRAM_MIN_MAX_DEFINES_SVH
`define VOXEL_HISTOGRAM_MIN_MAX_DEFINES_SVH

// The consequent must hold from the cycle after the antecedent.
`define VHMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram check failed: next-cycle property");

// The consequent must hold in the same cycle as the antecedent.
`define VHMM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram check failed: same-cycle property");

`endif

[rtl/vhmm_pkg.sv]
// Types and constants shared by the voxel histogram modules.
`default_nettype none
package vhmm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int RESULT_BITS = 32;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic {
      FMT_8BIT  = 1'b0,
      FMT_16BIT = 1'b1
   } fmt_type;

   typedef struct packed {
      cmd_type                command;
      logic [SAMPLE_BITS-1:0] sample;
      logic [SAMPLE_BITS-1:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] bin_count;
      logic [SAMPLE_BITS-1:0] min_value;
      logic [SAMPLE_BITS-1:0] max_value;
      logic [RESULT_BITS-1:0] peak_count;
      logic [RESULT_BITS-1:0] total_samples;
   } rsp_type;

   // Control from the sequencer to the tracker registers.
   typedef struct packed {
      logic                   clear;
      logic                   add;
      logic                   raise_peak;
      logic [SAMPLE_BITS-1:0] value;
   } trk_ctl_type;

endpackage
`default_nettype wire

[rtl/vhmm_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module vhmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/vhmm_trk.sv]
// Running minimum, maximum, peak bin count and sample total.
`default_nettype none
module vhmm_trk
   import vhmm_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire trk_ctl_type            ctl,
   input  wire logic [COUNT_BITS-1:0]  new_count,
   output logic      [SAMPLE_BITS-1:0] min_value,
   output logic      [SAMPLE_BITS-1:0] max_value,
   output logic      [COUNT_BITS-1:0]  peak_count,
   output logic      [COUNT_BITS-1:0]  total_samples
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [COUNT_BITS-1:0]  peak_ff, peak_in;
   logic [COUNT_BITS-1:0]  total_ff, total_in;

   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      peak_in  = peak_ff;
      total_in = total_ff;
      if (ctl.clear) begin
         min_in   = '1;
         max_in   = '0;
         peak_in  = '0;
         total_in = '0;
      end else if (ctl.add) begin
         if (ctl.value < min_ff) begin
            min_in = ctl.value;
         end
         if (ctl.value > max_ff) begin
            max_in = ctl.value;
         end
         if (ctl.raise_peak) begin
            peak_in = new_count;
         end
         if (total_ff != COUNT_MAX) begin
            total_in = total_ff + COUNT_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= '1;
         max_ff   <= '0;
         peak_ff  <= '0;
         total_ff <= '0;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         peak_ff  <= peak_in;
         total_ff <= total_in;
      end
   end

   assign min_value     = min_ff;
   assign max_value     = max_ff;
   assign peak_count    = peak_ff;
   assign total_samples = total_ff;

endmodule
`default_nettype wire

[rtl/voxel_histogram_min_max.sv]
// Voxel intensity histogram with minimum, maximum, peak and total tracking.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      beat taken when start high and busy low
//   response  rsp_strobe, rsp_data       one-cycle strobe, cannot be held off
//   control   csr_write_en, csr_write_data  written on any enabled edge outside reset
//
// For an add or a read the bin RAM is read in the accepting cycle; in the next, an add
// updates the registered data and writes it back, and a read returns it as the bin count.
// An unused command code answers in the cycle after it is taken. A clear answers
// in the same way but keeps busy high while the RAM is swept.
// After reset the same sweep runs before the first beat is taken.
// Results cannot be stalled, so the block never waits on the receiver.
`default_nettype none
module voxel_histogram_min_max
   import vhmm_pkg::*;
#(
   parameter int BIN_BITS   = 16,
   parameter int COUNT_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data,
   input  wire logic    csr_write_en,
   input  wire logic    csr_write_data
);

   localparam int                    BIN_DEPTH = 2 ** BIN_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_SWEEP  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [SAMPLE_BITS-1:0] val_ff, val_in;
   logic [BIN_BITS-1:0]    addr_ff, addr_in;
   logic [BIN_BITS-1:0]    sweep_ff, sweep_in;
   fmt_type                fmt_ff;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic [SAMPLE_BITS-1:0] smp_val;
   logic [SAMPLE_BITS-1:0] idx_val;
   logic                   accept;
   logic                   ram_wr_en;
   logic [BIN_BITS-1:0]    ram_wr_addr;
   logic [COUNT_BITS-1:0]  ram_wr_data;
   logic                   ram_rd_en;
   logic [BIN_BITS-1:0]    ram_rd_addr;
   logic [COUNT_BITS-1:0]  ram_rd_data;
   logic [COUNT_BITS-1:0]  bumped;
   trk_ctl_type            trk_ctl;
   logic [SAMPLE_BITS-1:0] trk_min;
   logic [SAMPLE_BITS-1:0] trk_max;
   logic [COUNT_BITS-1:0]  trk_peak;
   logic [COUNT_BITS-1:0]  trk_total;

   assign accept = start && (state_ff == ST_IDLE);

   // In 8-bit mode only the low byte counts, for the trackers as well.
   assign smp_val = (fmt_ff == FMT_16BIT) ? req_data.sample
                                          : {8'h00, req_data.sample[7:0]};
   assign idx_val = (fmt_ff == FMT_16BIT) ? req_data.bin_index
                                          : {8'h00, req_data.bin_index[7:0]};

   assign bumped = (ram_rd_data == COUNT_MAX) ? ram_rd_data : ram_rd_data + COUNT_ONE;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      addr_in       = addr_ff;
      sweep_in      = sweep_ff;
      rsp_strobe_in = 1'b0;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = addr_ff;
      ram_wr_data   = bumped;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = smp_val[BIN_BITS-1:0];
      trk_ctl       = '{clear: 1'b0, add: 1'b0, raise_peak: 1'b0, value: val_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_data.command;
               val_in  = smp_val;
               case (req_data.command)
                  CMD_CLEAR: begin
                     trk_ctl.clear = 1'b1;
                     sweep_in      = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_count_in  = '0;
                     state_in      = ST_SWEEP;
                  end
                  CMD_ADD: begin
                     ram_rd_en = 1'b1;
                     addr_in   = smp_val[BIN_BITS-1:0];
                     state_in  = ST_UPDATE;
                  end
                  CMD_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = idx_val[BIN_BITS-1:0];
                     addr_in     = idx_val[BIN_BITS-1:0];
                     state_in    = ST_UPDATE;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_count_in  = '0;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (cmd_ff == CMD_ADD) begin
               ram_wr_en          = 1'b1;
               trk_ctl.add        = 1'b1;
               // The new count exceeds the peak exactly when the old one reached it, short of saturation.
               trk_ctl.raise_peak = (ram_rd_data >= trk_peak);
               rsp_count_in       = bumped;
            end else begin
               rsp_count_in = ram_rd_data;
            end
         end
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            sweep_in    = sweep_ff + BIN_BITS'(1);
            if (sweep_ff == BIN_BITS'(BIN_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         fmt_ff        <= FMT_8BIT;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_en) begin
            fmt_ff <= fmt_type'(csr_write_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      val_ff       <= val_in;
      addr_ff      <= addr_in;
      rsp_count_ff <= rsp_count_in;
   end

   vhmm_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BIN_DEPTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   vhmm_trk #(
      .COUNT_BITS (COUNT_BITS)
   ) u_trk (
      .clock         (clock),
      .reset         (reset),
      .ctl           (trk_ctl),
      .new_count     (bumped),
      .min_value     (trk_min),
      .max_value     (trk_max),
      .peak_count    (trk_peak),
      .total_samples (trk_total)
   );

   // The trackers settle on the same edge as the strobe, so they are read live.
   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_data.bin_count     = RESULT_BITS'(rsp_count_ff);
   assign rsp_data.min_value     = trk_min;
   assign rsp_data.max_value     = trk_max;
   assign rsp_data.peak_count    = RESULT_BITS'(trk_peak);
   assign rsp_data.total_samples = RESULT_BITS'(trk_total);

endmodule
`default_nettype wire

[rtl/vhmm_chk.sv]
// Port-level checks for the voxel histogram, bound to the top level.
`default_nettype none
`include "voxel_histogram_min_max_defines.svh"
module vhmm_chk
   import vhmm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   logic take;
   assign take = start && !busy;

   // An add or a read makes the block busy, with no strobe, and then answers in the next cycle.
   `VHMM_ASSERT_NEXT(a_two_cycle, clock, reset, take && (req_data.command == CMD_ADD || req_data.command == CMD_READ), (busy && !rsp_strobe) ##1 rsp_strobe)

   // A clear answers with empty trackers.
   `VHMM_ASSERT_NEXT(a_clear_rsp, clock, reset, take && req_data.command == CMD_CLEAR, rsp_strobe && rsp_data.bin_count == 0 && rsp_data.min_value == 16'hFFFF && rsp_data.max_value == 0 && rsp_data.peak_count == 0 && rsp_data.total_samples == 0)

   // After an add the bin is non-empty and never above the peak, and the total is non-zero.
   `VHMM_ASSERT_NEXT(a_add_rsp, clock, reset, take && req_data.command == CMD_ADD, ##1 (rsp_data.bin_count != 0 && rsp_data.peak_count >= rsp_data.bin_count && rsp_data.total_samples != 0))

   // Once any sample has been counted the minimum cannot exceed the maximum.
   `VHMM_ASSERT_NOW(a_min_max, clock, reset, rsp_strobe && rsp_data.total_samples != 0, rsp_data.min_value <= rsp_data.max_value)

endmodule

bind voxel_histogram_min_max vhmm_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire
